@@ src/assert_macros.svh @@
// assertion macros shared by the oscillator bank rtl
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AOB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define AOB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/aob_pkg.sv @@
// shared types, codes and constants of the additive oscillator bank
// no dependencies; used by the unit, aob_ram, aob_sine and aob_mul
package aob_pkg;

  // default sizes
  localparam int PARTIALS     = 64;
  localparam int SINE_ENTRIES = 4096;

  // item codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int   CFG_IDX_W  = 1;
  localparam int   CFG_DATA_W = 24;
  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_VOLUME = 1'b1;

  localparam int ACTIVE_W = 7;
  localparam int VOL_W    = 24;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd10;
  localparam logic [VOL_W-1:0]    VOLUME_RESET = 24'd2560000;

  // partial table fields
  typedef enum logic [3:0] {
    FLD_AMP, FLD_AMP_TGT, FLD_INC, FLD_INC_TGT, FLD_TONE_PH, FLD_PAN,
    FLD_TREM_DEPTH, FLD_TREM_INC, FLD_TREM_PH, FLD_AM_DEPTH, FLD_AM_INC, FLD_AM_PH
  } field_t;
  localparam int NUM_FIELDS = 12;

  // datapath widths
  localparam int MAG_W   = 15;
  localparam int SINE_W  = 16;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 26;
  localparam int LFO_W   = 18;
  localparam int TONE_W  = 33;
  localparam int C_W     = 28;

  // output limits and gain control
  localparam int VOL_DECAY = 64880;
  localparam int SUM_LIMIT = 32000;
  localparam int CLIP_MAX  = 32767;
  localparam int LOUD_MAX  = 16000;

  // address width of a store with depth entries
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // stored width of each table field
  function automatic int field_width(input int f);
    case (f)
      FLD_AMP, FLD_AMP_TGT, FLD_PAN, FLD_TREM_DEPTH, FLD_AM_DEPTH: return 16;
      default: return 32;
    endcase
  endfunction

endpackage

@@ src/aob_in_if.sv @@
// input item channel of the oscillator bank
// no dependencies
interface aob_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [5:0]  partial_index;
  logic [3:0]  field_select;
  logic [31:0] write_value;

  modport source (output valid, operation, partial_index, field_select, write_value,
                  input ready);
  modport sink   (input valid, operation, partial_index, field_select, write_value,
                  output ready);
endinterface

@@ src/aob_out_if.sv @@
// result item channel of the oscillator bank
// no dependencies
interface aob_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_sample;
  logic signed [15:0] left_sample;
  logic               gain_reduced;
  logic               loud;

  modport source (output valid, right_sample, left_sample, gain_reduced, loud,
                  input ready);
  modport sink   (input valid, right_sample, left_sample, gain_reduced, loud,
                  output ready);
endinterface

@@ src/additive_oscillator_bank_unit.sv @@
// Additive oscillator bank, top level: sequencer, partial table rams, shared
// multiplier and sine table. A write item stores one table word as it is taken. A
// sample item walks n partials, n being the active partial count capped at PARTIALS,
// and then waits for the result register if it is still full: each partial passes
// nine steps through the one shared multiplier and the sine table.
// After reset a clearing pass zeroes the table; no item is taken meanwhile,
// configuration writes are. Depends on aob_pkg, aob_in_if, aob_out_if,
// aob_ram, aob_sine, aob_mul and assert_macros.svh.
`include "assert_macros.svh"

module additive_oscillator_bank_unit #(
  parameter int PARTIALS     = aob_pkg::PARTIALS,
  parameter int SINE_ENTRIES = aob_pkg::SINE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  aob_in_if.sink                         in_ch,
  aob_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [aob_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aob_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW     = aob_pkg::addr_w(PARTIALS);
  localparam int CNT_W  = $clog2(PARTIALS + 1);
  localparam int ACC_W  = 45 + $clog2(PARTIALS + 1);
  localparam int A_W    = aob_pkg::MUL_A_W;
  localparam int B_W    = aob_pkg::MUL_B_W;
  localparam int P_W    = A_W + B_W;
  localparam int NF     = aob_pkg::NUM_FIELDS;
  localparam logic signed [ACC_W-1:0] LIM      = ACC_W'(aob_pkg::SUM_LIMIT) <<< 24;
  localparam logic signed [ACC_W-1:0] CLIP_HI  = ACC_W'(aob_pkg::CLIP_MAX);
  localparam logic signed [ACC_W-1:0] ROUND_IN = ACC_W'((1 << 24) - 1);
  localparam logic signed [15:0]      LOUD_HI  = 16'(aob_pkg::LOUD_MAX);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_FIN1, S_FIN2, S_OUT
  } state_t;

  state_t                       state_r;
  logic [AW-1:0]                clr_r;
  logic [CNT_W-1:0]             idx_r;
  logic [CNT_W-1:0]             n_r;
  logic [aob_pkg::ACTIVE_W-1:0] active_r;
  logic [aob_pkg::VOL_W-1:0]    vol_r;

  // per-partial working registers
  logic [15:0]                  amp_old_r, pan_r, trem_depth_r, am_depth_r;
  logic [31:0]                  inc_old_r, tone_ph_r, tp_r, ap_r;
  logic signed [aob_pkg::TONE_W-1:0] tone_r;
  logic signed [aob_pkg::LFO_W-1:0]  tf_r, af_r;
  logic signed [aob_pkg::C_W-1:0]    c_r;
  logic signed [ACC_W-1:0]      rsum_r, lsum_r;
  logic signed [15:0]           rs_r, ls_r;
  logic                         red_r;

  // output register
  logic                         out_valid_r;
  logic signed [15:0]           out_right_r, out_left_r;
  logic                         out_red_r, out_loud_r;

  // table ram ports
  logic [NF-1:0]                ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [31:0]                  ram_wdata [NF];
  logic [31:0]                  ram_rdata [NF];

  logic [15:0]                  idx_ext;
  logic [AW-1:0]                item_addr;
  logic                         item_take;
  logic                         item_write;

  logic [31:0]                  sine_phase;
  logic signed [aob_pkg::SINE_W-1:0] sine_val;
  logic signed [A_W-1:0]        mul_a;
  logic signed [B_W-1:0]        mul_b;
  logic signed [P_W-1:0]        prod;

  logic signed [aob_pkg::C_W-1:0]    c_now;
  logic signed [aob_pkg::LFO_W-1:0]  lfo_now;
  logic [31:0]                  step_now;
  logic [31:0]                  tp_now, ap_now;
  logic signed [ACC_W-1:0]      rs_t, ls_t;
  logic                         red_now;

  // glide one step toward the target, never stalling short of it
  function automatic logic [31:0] glide(input logic [31:0] now_v, input logic [31:0] tgt_v);
    logic signed [32:0] d;
    logic signed [32:0] s;
    d = $signed({1'b0, tgt_v}) - $signed({1'b0, now_v});
    s = d >>> 10;
    if (s == 33'sd0 && d != 33'sd0) begin
      s = 33'sd1;
    end
    return now_v + s[31:0];
  endfunction

  // truncate a sum toward zero and clip it to the sample range
  function automatic logic signed [15:0] to_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v < 0) ? ((v + ROUND_IN) >>> 24) : (v >>> 24);
    if (t > CLIP_HI) begin
      t = CLIP_HI;
    end else if (t < -CLIP_HI) begin
      t = -CLIP_HI;
    end
    return 16'(t);
  endfunction

  // partial table, one ram per field
  for (genvar f = 0; f < NF; f++) begin : g_field
    localparam int FW = aob_pkg::field_width(f);
    logic [FW-1:0] rd_raw;
    aob_ram #(.WIDTH(FW), .DEPTH(PARTIALS)) u_ram (
      .clk   (clk),
      .we    (ram_we[f]),
      .waddr (ram_waddr),
      .wdata (FW'(ram_wdata[f])),
      .raddr (ram_raddr),
      .rdata (rd_raw)
    );
    assign ram_rdata[f] = 32'(rd_raw);
  end

  aob_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine (
    .clk     (clk),
    .phase_i (sine_phase),
    .sine_o  (sine_val)
  );

  aob_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // input handshake and item decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign item_take   = in_ch.valid && (state_r == S_IDLE);
  assign idx_ext     = 16'(in_ch.partial_index);
  assign item_addr   = idx_ext[AW-1:0];
  assign item_write  = item_take && (in_ch.operation == aob_pkg::OP_WRITE) &&
                       (int'(in_ch.partial_index) < PARTIALS) &&
                       (int'(in_ch.field_select) < NF);
  assign ram_raddr   = idx_r[AW-1:0];

  // lfo phases advance before they are read
  assign tp_now = ram_rdata[aob_pkg::FLD_TREM_PH] + ram_rdata[aob_pkg::FLD_TREM_INC];
  assign ap_now = ram_rdata[aob_pkg::FLD_AM_PH] + ram_rdata[aob_pkg::FLD_AM_INC];

  // product slices
  assign lfo_now  = aob_pkg::LFO_W'(prod >>> 15) + aob_pkg::LFO_W'(32768);
  assign step_now = 32'(prod >>> 15);
  assign c_now    = aob_pkg::C_W'(prod >>> 30);

  // ram write selection: clearing pass, table item, or partial write-back
  always_comb begin
    ram_we    = '0;
    ram_waddr = idx_r[AW-1:0];
    for (int f = 0; f < NF; f++) begin
      ram_wdata[f] = '0;
    end
    case (state_r)
      S_CLEAR: begin
        ram_we    = '1;
        ram_waddr = clr_r;
      end
      S_IDLE: begin
        ram_waddr = item_addr;
        for (int f = 0; f < NF; f++) begin
          ram_wdata[f] = in_ch.write_value;
          ram_we[f]    = item_write && (in_ch.field_select == 4'(f));
        end
      end
      S_P1: begin
        ram_we[aob_pkg::FLD_AMP]     = 1'b1;
        ram_we[aob_pkg::FLD_INC]     = 1'b1;
        ram_we[aob_pkg::FLD_TREM_PH] = 1'b1;
        ram_we[aob_pkg::FLD_AM_PH]   = 1'b1;
        ram_wdata[aob_pkg::FLD_AMP]  = glide(ram_rdata[aob_pkg::FLD_AMP],
                                             ram_rdata[aob_pkg::FLD_AMP_TGT]);
        ram_wdata[aob_pkg::FLD_INC]  = glide(ram_rdata[aob_pkg::FLD_INC],
                                             ram_rdata[aob_pkg::FLD_INC_TGT]);
        ram_wdata[aob_pkg::FLD_TREM_PH] = tp_now;
        ram_wdata[aob_pkg::FLD_AM_PH]   = ap_now;
      end
      S_P6: begin
        ram_we[aob_pkg::FLD_TONE_PH]    = 1'b1;
        ram_wdata[aob_pkg::FLD_TONE_PH] = tone_ph_r + step_now;
      end
      default: begin
      end
    endcase
  end

  // sine table address
  always_comb begin
    case (state_r)
      S_P1:    sine_phase = ram_rdata[aob_pkg::FLD_TONE_PH];
      S_P2:    sine_phase = tp_r;
      default: sine_phase = ap_r;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = A_W'(vol_r);
    mul_b = B_W'(aob_pkg::VOL_DECAY);
    case (state_r)
      S_P2: begin
        mul_a = A_W'(amp_old_r);
        mul_b = B_W'(sine_val);
      end
      S_P3: begin
        mul_a = A_W'(trem_depth_r);
        mul_b = B_W'(sine_val);
      end
      S_P4: begin
        mul_a = A_W'(am_depth_r);
        mul_b = B_W'(sine_val);
      end
      S_P5: begin
        mul_a = A_W'(inc_old_r);
        mul_b = B_W'(tf_r);
      end
      S_P6: begin
        mul_a = A_W'(tone_r);
        mul_b = B_W'(af_r);
      end
      S_P7: begin
        mul_a = A_W'(prod >>> 15);
        mul_b = B_W'(vol_r);
      end
      S_P8: begin
        mul_a = A_W'(c_now);
        mul_b = B_W'(pan_r);
      end
      default: begin
      end
    endcase
  end

  // gain check and sample shaping at the end of a sample
  assign red_now = (rsum_r > LIM) || (rsum_r < -LIM) || (lsum_r > LIM) || (lsum_r < -LIM);
  assign rs_t    = rsum_r;
  assign ls_t    = lsum_r;

  // sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      active_r    <= aob_pkg::ACTIVE_RESET;
      vol_r       <= aob_pkg::VOLUME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(PARTIALS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_take && in_ch.operation == aob_pkg::OP_SAMPLE) begin
            idx_r  <= '0;
            rsum_r <= '0;
            lsum_r <= '0;
            if (int'(active_r) > PARTIALS) begin
              n_r     <= CNT_W'(PARTIALS);
              state_r <= S_P0;
            end else begin
              n_r     <= CNT_W'(active_r);
              state_r <= (active_r == '0) ? S_FIN1 : S_P0;
            end
          end
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          amp_old_r    <= ram_rdata[aob_pkg::FLD_AMP][15:0];
          inc_old_r    <= ram_rdata[aob_pkg::FLD_INC];
          tone_ph_r    <= ram_rdata[aob_pkg::FLD_TONE_PH];
          pan_r        <= ram_rdata[aob_pkg::FLD_PAN][15:0];
          trem_depth_r <= ram_rdata[aob_pkg::FLD_TREM_DEPTH][15:0];
          am_depth_r   <= ram_rdata[aob_pkg::FLD_AM_DEPTH][15:0];
          tp_r         <= tp_now;
          ap_r         <= ap_now;
          state_r      <= S_P2;
        end
        S_P2: state_r <= S_P3;
        S_P3: begin
          tone_r  <= aob_pkg::TONE_W'(prod);
          state_r <= S_P4;
        end
        S_P4: begin
          tf_r    <= lfo_now;
          state_r <= S_P5;
        end
        S_P5: begin
          af_r    <= lfo_now;
          state_r <= S_P6;
        end
        S_P6: state_r <= S_P7;
        S_P7: state_r <= S_P8;
        S_P8: begin
          c_r     <= c_now;
          idx_r   <= idx_r + CNT_W'(1);
          state_r <= S_P9;
        end
        S_P9: begin
          rsum_r  <= rsum_r + ACC_W'(prod);
          lsum_r  <= lsum_r + (ACC_W'(c_r) <<< 16) - ACC_W'(prod);
          state_r <= (idx_r == n_r) ? S_FIN1 : S_P1;
        end
        S_FIN1: begin
          red_r   <= red_now;
          rs_r    <= to_sample(rs_t);
          ls_r    <= to_sample(ls_t);
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          if (red_r) begin
            vol_r <= aob_pkg::VOL_W'(prod >>> 16);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_right_r <= rs_r;
            out_left_r  <= ls_r;
            out_red_r   <= red_r;
            out_loud_r  <= (rs_r > LOUD_HI) || (rs_r < -LOUD_HI) ||
                           (ls_r > LOUD_HI) || (ls_r < -LOUD_HI);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          aob_pkg::CFG_ACTIVE: active_r <= cfg_data[aob_pkg::ACTIVE_W-1:0];
          aob_pkg::CFG_VOLUME: vol_r    <= cfg_data[aob_pkg::VOL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.right_sample = out_right_r;
  assign out_ch.left_sample  = out_left_r;
  assign out_ch.gain_reduced = out_red_r;
  assign out_ch.loud         = out_loud_r;

  // checks
  `AOB_ASSERT_NXT(a_sample_starts, item_take && in_ch.operation == aob_pkg::OP_SAMPLE, state_r == S_P0 || state_r == S_FIN1, "sample item did not start the walk")
  `AOB_ASSERT_IMP(a_idx_range, state_r == S_P1, idx_r < n_r, "partial index past active count")
  `AOB_ASSERT_IMP(a_out_source, $rose(out_valid_r), $past(state_r) == S_OUT, "result shown outside the output step")
  `AOB_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r && ram_we == '1, "clearing pass overlaps other work")

endmodule

@@ src/aob_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on aob_pkg for the address width
module aob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = aob_pkg::PARTIALS
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [aob_pkg::addr_w(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [aob_pkg::addr_w(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/aob_sine.sv @@
// sine lookup: constant magnitude table built at elaboration, registered output
// depends on aob_pkg for widths
module aob_sine #(
  parameter int SINE_ENTRIES = aob_pkg::SINE_ENTRIES
) (
  input  logic                              clk,
  input  logic [31:0]                       phase_i,
  output logic signed [aob_pkg::SINE_W-1:0] sine_o
);
  localparam int LOG_N = $clog2(SINE_ENTRIES);
  localparam int HALF  = SINE_ENTRIES / 2;
  localparam longint unsigned N = longint'(SINE_ENTRIES);

  logic [aob_pkg::MAG_W-1:0] mag [HALF];
  logic [LOG_N-1:0]          idx;
  logic [LOG_N-2:0]          half_idx;
  logic                      neg;
  logic [aob_pkg::MAG_W-1:0] m;

  // magnitude over one half cycle, rounded rational sine approximation
  for (genvar j = 0; j < HALF; j++) begin : g_tab
    localparam longint unsigned Q   = 2 * longint'(j);
    localparam longint unsigned P   = Q * (N - Q);
    localparam longint unsigned DEN = 5 * N * N - 4 * P;
    localparam longint unsigned NUM = 32767 * 16 * P;
    localparam longint unsigned V   = (2 * NUM + DEN) / (2 * DEN);
    assign mag[j] = aob_pkg::MAG_W'(V);
  end

  // top phase bits select the entry, msb picks the negative half
  assign idx      = phase_i[31 -: LOG_N];
  assign neg      = idx[LOG_N-1];
  assign half_idx = idx[LOG_N-2:0];
  assign m        = mag[half_idx];

  always_ff @(posedge clk) begin
    if (neg) begin
      sine_o <= -$signed({1'b0, m});
    end else begin
      sine_o <= $signed({1'b0, m});
    end
  end
endmodule

@@ src/aob_mul.sv @@
// shared signed multiplier with registered product
// depends on aob_pkg for the operand widths
module aob_mul #(
  parameter int A_W = aob_pkg::MUL_A_W,
  parameter int B_W = aob_pkg::MUL_B_W
) (
  input  logic                    clk,
  input  logic signed [A_W-1:0]   a_i,
  input  logic signed [B_W-1:0]   b_i,
  output logic signed [A_W+B_W-1:0] p_o
);
  always_ff @(posedge clk) begin
    p_o <= a_i * b_i;
  end
endmodule

@@ tb/tb_additive_oscillator_bank_unit.sv @@
// self-checking testbench of additive_oscillator_bank_unit: a scoreboard class
// predicts every sample item and checks each result. Depends on aob_pkg,
// aob_in_if, aob_out_if and the block itself
module tb_additive_oscillator_bank_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 600;   // covers the longest sample
  localparam int RANDOM_ITEMS = 110;
  localparam int NP           = aob_pkg::PARTIALS;

  typedef struct {
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic               reduced;
    logic               loud;
  } stereo_t;

  // bank predictor plus queue of expected samples
  class bank_scoreboard;
    logic [aob_pkg::ACTIVE_W-1:0] active;
    logic [aob_pkg::VOL_W-1:0]    volume;
    logic [15:0] amp[NP], amp_tgt[NP], pan[NP];
    logic [15:0] trem_dep[NP], am_dep[NP];
    logic [31:0] inc[NP], inc_tgt[NP], tone_ph[NP];
    logic [31:0] trem_inc[NP], trem_ph[NP], am_inc[NP];
    logic [31:0] am_ph[NP];
    stereo_t     samples_due[$];
    int          failures;

    function new();
      active = aob_pkg::ACTIVE_RESET;
      volume = aob_pkg::VOLUME_RESET;
      failures = 0;
      for (int i = 0; i < NP; i++) begin
        amp[i] = 0; amp_tgt[i] = 0; pan[i] = 0; trem_dep[i] = 0; am_dep[i] = 0;
        inc[i] = 0; inc_tgt[i] = 0; tone_ph[i] = 0; trem_inc[i] = 0;
        trem_ph[i] = 0; am_inc[i] = 0; am_ph[i] = 0;
      end
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    function void set_reg(input logic idx, input logic [aob_pkg::CFG_DATA_W-1:0] val);
      if (idx == aob_pkg::CFG_ACTIVE) active = val[aob_pkg::ACTIVE_W-1:0];
      else volume = val;
    endfunction

    // integer sine approximation, signed Q15
    function longint sine_of(input logic [31:0] ph);
      longint unsigned n, i, q, p, den, num;
      longint v;
      bit neg;
      n = aob_pkg::SINE_ENTRIES;
      i = ({32'd0, ph} * n) >> 32;
      q = 2 * i;
      neg = q >= n;
      if (neg) q = q - n;
      p = q * (n - q);
      den = 5 * n * n - 4 * p;
      num = 64'd32767 * 64'd16 * p;
      v = longint'((2 * num + den) / (2 * den));
      return neg ? -v : v;
    endfunction

    function longint lfo(input logic [15:0] depth, input logic [31:0] ph);
      return 32768 + ((longint'(depth) * sine_of(ph)) >>> 15);
    endfunction

    function longint glide(input longint cur, input longint tgt);
      longint d, s;
      d = tgt - cur;
      s = d >>> 10;
      if (s == 0 && d != 0) s = (d > 0) ? 1 : -1;
      return cur + s;
    endfunction

    function longint clip(input longint sum);
      longint v;
      v = (sum < 0) ? -((-sum) >>> 24) : (sum >>> 24);
      if (v > aob_pkg::CLIP_MAX) v = aob_pkg::CLIP_MAX;
      if (v < -aob_pkg::CLIP_MAX) v = -aob_pkg::CLIP_MAX;
      return v;
    endfunction

    // update the table or predict one sample for an accepted item
    function void note_item(input logic op, input logic [5:0] idx,
                            input logic [3:0] fld, input logic [31:0] val);
      int n;
      longint vol, rsum, lsum, lim, tone, tf, stp, af, t2, c, rs, ls;
      stereo_t s;
      if (op == aob_pkg::OP_WRITE) begin
        case (fld)
          aob_pkg::FLD_AMP:        amp[idx] = val[15:0];
          aob_pkg::FLD_AMP_TGT:    amp_tgt[idx] = val[15:0];
          aob_pkg::FLD_INC:        inc[idx] = val;
          aob_pkg::FLD_INC_TGT:    inc_tgt[idx] = val;
          aob_pkg::FLD_TONE_PH:    tone_ph[idx] = val;
          aob_pkg::FLD_PAN:        pan[idx] = val[15:0];
          aob_pkg::FLD_TREM_DEPTH: trem_dep[idx] = val[15:0];
          aob_pkg::FLD_TREM_INC:   trem_inc[idx] = val;
          aob_pkg::FLD_TREM_PH:    trem_ph[idx] = val;
          aob_pkg::FLD_AM_DEPTH:   am_dep[idx] = val[15:0];
          aob_pkg::FLD_AM_INC:     am_inc[idx] = val;
          aob_pkg::FLD_AM_PH:      am_ph[idx] = val;
          default: ;
        endcase
        return;
      end
      n = (active > NP) ? NP : active;
      vol = longint'(volume);
      rsum = 0;
      lsum = 0;
      lim = longint'(aob_pkg::SUM_LIMIT) <<< 24;
      for (int i = 0; i < n; i++) begin
        tone = longint'(amp[i]) * sine_of(tone_ph[i]);
        trem_ph[i] = trem_ph[i] + trem_inc[i];
        tf = lfo(trem_dep[i], trem_ph[i]);
        stp = (longint'(inc[i]) * tf) >>> 15;
        tone_ph[i] = tone_ph[i] + stp[31:0];
        amp[i] = 16'(glide(longint'(amp[i]), longint'(amp_tgt[i])));
        inc[i] = 32'(glide(longint'(inc[i]), longint'(inc_tgt[i])));
        am_ph[i] = am_ph[i] + am_inc[i];
        af = lfo(am_dep[i], am_ph[i]);
        t2 = (tone * af) >>> 15;
        c = (t2 * vol) >>> 30;
        rsum += c * longint'(pan[i]);
        lsum += c * (65536 - longint'(pan[i]));
      end
      s.reduced = rsum > lim || rsum < -lim || lsum > lim || lsum < -lim;
      if (s.reduced)
        volume = aob_pkg::VOL_W'((longint'(volume) * aob_pkg::VOL_DECAY) >> 16);
      rs = clip(rsum);
      ls = clip(lsum);
      s.right = rs[15:0];
      s.left = ls[15:0];
      s.loud = rs > aob_pkg::LOUD_MAX || rs < -aob_pkg::LOUD_MAX ||
               ls > aob_pkg::LOUD_MAX || ls < -aob_pkg::LOUD_MAX;
      samples_due.push_back(s);
    endfunction

    function void check_result(input stereo_t got);
      stereo_t want;
      if (samples_due.size() == 0) begin
        $error("unexpected sample item r=%0d l=%0d", got.right, got.left);
        failures++;
        return;
      end
      want = samples_due.pop_front();
      if (got.right !== want.right) begin
        $error("right_sample expected %0d actual %0d", want.right, got.right);
        failures++;
      end
      if (got.left !== want.left) begin
        $error("left_sample expected %0d actual %0d", want.left, got.left);
        failures++;
      end
      if (got.reduced !== want.reduced) begin
        $error("gain_reduced expected %0b actual %0b", want.reduced, got.reduced);
        failures++;
      end
      if (got.loud !== want.loud) begin
        $error("loud expected %0b actual %0b", want.loud, got.loud);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [aob_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [aob_pkg::CFG_DATA_W-1:0] cfg_data;
  aob_in_if  in_ch();
  aob_out_if out_ch();
  bank_scoreboard sb;
  int  cycles;
  bit  no_gaps;
  stereo_t seen;

  additive_oscillator_bank_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("additive_oscillator_bank_unit verification failed");
      $finish;
    end
  end

  // sample result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.right = out_ch.right_sample;
      seen.left = out_ch.left_sample;
      seen.reduced = out_ch.gain_reduced;
      seen.loud = out_ch.loud;
      sb.check_result(seen);
    end
  end

  // receiver with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      out_ch.ready = 1'b0;
    end
  end

  // one input item, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic op, input logic [5:0] idx,
                           input logic [3:0] fld, input logic [31:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.partial_index = idx;
    in_ch.field_select = fld;
    in_ch.write_value = val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(op, idx, fld, val);
    @(negedge clk);
  endtask

  task automatic write_field(input logic [5:0] idx, input aob_pkg::field_t f,
                             input logic [31:0] val);
    send_item(aob_pkg::OP_WRITE, idx, f, val);
  endtask

  task automatic sample();
    send_item(aob_pkg::OP_SAMPLE, 6'($urandom), 4'($urandom), $urandom);
  endtask

  // drain all expected samples and let the block settle
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [aob_pkg::CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random mix of table writes and samples under one register setting
  task automatic random_phase(input int act, input int vol, input bit quiet);
    wait_idle();
    write_reg(aob_pkg::CFG_ACTIVE, aob_pkg::CFG_DATA_W'(act));
    write_reg(aob_pkg::CFG_VOLUME, aob_pkg::CFG_DATA_W'(vol));
    no_gaps = quiet;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 99) < 30) sample();
      else if ($urandom_range(0, 9) == 0)
        send_item(aob_pkg::OP_WRITE, 6'($urandom), 4'($urandom_range(12, 15)),
                  $urandom);
      else send_item(aob_pkg::OP_WRITE, 6'($urandom_range(0, 11)),
                     4'($urandom_range(0, 11)), $urandom);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    sb = new();
    no_gaps = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = aob_pkg::CFG_ACTIVE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = aob_pkg::OP_WRITE;
    in_ch.partial_index = '0;
    in_ch.field_select = '0;
    in_ch.write_value = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset gains, full-scale partial, negative tremolo, glide, ignored fields
    sample();
    write_field(6'd0, aob_pkg::FLD_AMP, 32'hFFFF_FFFF);
    write_field(6'd0, aob_pkg::FLD_AMP_TGT, 32'h0000_FFFE);
    write_field(6'd0, aob_pkg::FLD_INC, 32'h0100_0000);
    write_field(6'd0, aob_pkg::FLD_INC_TGT, 32'hFFFF_FFFF);
    write_field(6'd0, aob_pkg::FLD_TONE_PH, 32'h4000_0000);
    write_field(6'd0, aob_pkg::FLD_PAN, 32'h0000_8000);
    write_field(6'd0, aob_pkg::FLD_TREM_DEPTH, 32'h0000_FFFF);
    write_field(6'd0, aob_pkg::FLD_TREM_PH, 32'hC000_0000);
    write_field(6'd0, aob_pkg::FLD_AM_DEPTH, 32'h0000_FFFF);
    write_field(6'd0, aob_pkg::FLD_AM_INC, 32'h0800_0000);
    write_field(6'd0, aob_pkg::FLD_AM_PH, 32'h8000_0000);
    write_field(6'd63, aob_pkg::FLD_TREM_INC, 32'hFFFF_FFFF);
    send_item(aob_pkg::OP_WRITE, 6'd0, 4'd12, 32'h0);
    send_item(aob_pkg::OP_WRITE, 6'd0, 4'd15, 32'hFFFF_FFFF);
    sample();
    sample();
    sample();
    wait_idle();
    write_reg(aob_pkg::CFG_ACTIVE, 24'd127);
    write_reg(aob_pkg::CFG_VOLUME, 24'hFF_FFFF);
    sample();
    sample();
    sample();
    write_field(6'd1, aob_pkg::FLD_AMP, 32'h0000_7FFF);
    write_field(6'd1, aob_pkg::FLD_AMP_TGT, 32'h0000_0000);
    sample();
    wait_idle();
    write_reg(aob_pkg::CFG_ACTIVE, 24'd0);
    write_reg(aob_pkg::CFG_VOLUME, 24'd0);
    sample();

    // random phases over several register settings
    random_phase(10, 2560000, 1'b0);
    random_phase(64, 16777215, 1'b1);
    random_phase(1, 0, 1'b0);
    random_phase(3, int'($urandom_range(0, 16777215)), 1'b0);
    random_phase(127, int'($urandom_range(1000000, 16777215)), 1'b0);

    wait_idle();
    if (sb.failures == 0)
      $display("additive_oscillator_bank_unit verification clean");
    else
      $display("additive_oscillator_bank_unit verification failed");
    $finish;
  end
endmodule
